FILE: src/nrps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_pkg: shared types and constants for the nearest route point search
// Beat layouts for the request and response channels, request codes, field
// widths, default sizes and the scan state encoding.
// ----------------------------------------------------------------------------
package nrps_pkg;

   localparam int FIELD_BITS     = 24;   // coordinate field width on the port
   localparam int INDEX_BITS     = 10;   // point_index / closest_index width
   localparam int COUNT_BITS     = 11;   // point_count register width
   localparam int EXT_BITS       = 32;   // working width for extensions

   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_COORD_BITS = 24;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                         req_type;
      logic [INDEX_BITS-1:0]        point_index;
      logic signed [FIELD_BITS-1:0] coord_x;
      logic signed [FIELD_BITS-1:0] coord_y;
      logic signed [FIELD_BITS-1:0] coord_z;
   } nrps_req_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] closest_index;
   } nrps_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } nrps_state_type;

endpackage

FILE: src/nrps_point_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_point_store: route point memory
// One write port and one registered read port; each entry packs x, y, z.
// ----------------------------------------------------------------------------
module nrps_point_store
   import nrps_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   input  logic [3*COORD_BITS-1:0]       wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
   output logic [3*COORD_BITS-1:0]       rd_data
);

   logic [3*COORD_BITS-1:0] mem [MAX_POINTS];
   logic [3*COORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/nrps_dist_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_dist_unit: pipelined squared distance unit
// Takes one stored point per cycle and produces its squared Euclidean
// distance to the held query location via registered |d|, square and sum.
// ----------------------------------------------------------------------------
module nrps_dist_unit
   import nrps_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_load,
   input  logic [3*COORD_BITS-1:0]     q_point,
   input  logic                        in_valid,
   input  logic [3*COORD_BITS-1:0]     pt_data,
   output logic                        out_valid,
   output logic [2*COORD_BITS+1:0]     out_dist
);

   localparam int CB   = COORD_BITS;
   localparam int SQ_W = 2*COORD_BITS + 2;

   logic [3*CB-1:0] q_point_ff;
   logic            v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CB:0]     ad_in [3];
   logic [CB:0]     ad_ff [3];
   logic [SQ_W-1:0] sq_in [3];
   logic [SQ_W-1:0] sq_ff [3];
   logic [SQ_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (q_load) begin
         q_point_ff <= q_point;
      end
   end

   // v1 lines up with the registered memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      logic [CB-1:0] p;
      logic [CB-1:0] q;
      logic [CB:0]   d;
      for (int k = 0; k < 3; k++) begin
         p        = pt_data[k*CB +: CB];
         q        = q_point_ff[k*CB +: CB];
         d        = {p[CB-1], p} - {q[CB-1], q};
         ad_in[k] = d[CB] ? (~d + 1'b1) : d;
         sq_in[k] = ad_ff[k] * ad_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ad_ff[k] <= ad_in[k];
         sq_ff[k] <= sq_in[k];
      end
      sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   assign out_valid = v4_ff;
   assign out_dist  = sum_ff;

endmodule

FILE: src/nrps_scan_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_scan_ctrl: query sequencer and running minimum
// Walks the store addresses, tracks the nearest entry as distances come
// back and issues the response beat.
// ----------------------------------------------------------------------------
module nrps_scan_ctrl
   import nrps_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_query,
   input  logic [COUNT_BITS-1:0]         point_count,
   input  logic                          dist_valid,
   input  logic [2*COORD_BITS+1:0]       dist_sum,
   output logic                          busy,
   output logic                          rd_en,
   output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
   output logic                          rsp_valid,
   output nrps_rsp_type                  rsp_data
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int SUM_W = 2*COORD_BITS + 2;

   nrps_state_type          state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [SUM_W-1:0]        best_ff, best_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   nrps_rsp_type            rsp_data_ff, rsp_data_in;

   logic [EXT_BITS-1:0]     pc_ext;
   logic [EXT_BITS-1:0]     n_eff;
   logic                    take;
   logic                    is_last;
   logic [IDX_W-1:0]        win_idx;

   // clamp the scan length to the store depth
   assign pc_ext  = EXT_BITS'(point_count);
   assign n_eff   = (pc_ext > EXT_BITS'(MAX_POINTS)) ? EXT_BITS'(MAX_POINTS) : pc_ext;

   // first entry always wins; later ones only when strictly closer
   assign take    = dist_valid && ((cmp_idx_ff == '0) || (dist_sum < best_ff));
   assign is_last = dist_valid && (cmp_idx_ff == last_idx_ff);
   assign win_idx = take ? cmp_idx_ff : best_idx_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (dist_valid) begin
         cmp_idx_in = cmp_idx_ff + 1'b1;
      end
      if (take) begin
         best_in     = dist_sum;
         best_idx_in = cmp_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start_query) begin
               if (n_eff == '0) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.found         = 1'b0;
                  rsp_data_in.closest_index = '0;
               end else begin
                  state_in    = ST_SCAN;
                  idx_in      = '0;
                  cmp_idx_in  = '0;
                  last_idx_in = IDX_W'(n_eff - 1);
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the last distance has been compared
            if (is_last) begin
               state_in                  = ST_IDLE;
               rsp_valid_in              = 1'b1;
               rsp_data_in.found         = 1'b1;
               rsp_data_in.closest_index = INDEX_BITS'(win_idx);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rd_en     = (state_ff == ST_SCAN);
   assign rd_addr   = idx_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/nearest_route_point_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_route_point_search_unit: nearest stored 3-D point lookup
// Keeps a store of route points and returns the index of the one nearest
// to a query location.
// ----------------------------------------------------------------------------
// A write beat (req_type 0) stores a point and busy stays low.
// A query beat (req_type 1) scans entries 0 .. N-1, N = min(point_count,
// MAX_POINTS), through one pipelined squared-distance unit fed by a single
// memory read port at one entry per cycle; busy stays high through the scan
// and the response beat appears in the same cycle that busy falls. With N = 0
// the response (found = 0) appears on the next cycle and busy stays low.
// Every query produces exactly one response beat, shown for one cycle with
// rsp_valid; it cannot be held off, so the receiver must take it then.
// Ties resolve to the lowest index. Write point_count only while idle.
module nearest_route_point_search_unit
   import nrps_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  nrps_req_type          req_data,
   output logic                  rsp_valid,
   output nrps_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CB    = COORD_BITS;

   logic [COUNT_BITS-1:0] point_count_ff;
   logic                  accept;
   logic                  start_query;
   logic                  wr_en;
   logic [EXT_BITS-1:0]   x_ext, y_ext, z_ext;
   logic [3*CB-1:0]       in_point;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [3*CB-1:0]       rd_data;
   logic                  dist_valid;
   logic [2*CB+1:0]       dist_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         point_count_ff <= csr_data;
      end
   end

   assign accept      = start && !busy;
   assign start_query = accept && (req_data.req_type == REQ_QUERY);
   // drop writes beyond the store
   assign wr_en       = accept && (req_data.req_type == REQ_WRITE) &&
                        (EXT_BITS'(req_data.point_index) < EXT_BITS'(MAX_POINTS));

   assign x_ext = {{(EXT_BITS-FIELD_BITS){req_data.coord_x[FIELD_BITS-1]}}, req_data.coord_x};
   assign y_ext = {{(EXT_BITS-FIELD_BITS){req_data.coord_y[FIELD_BITS-1]}}, req_data.coord_y};
   assign z_ext = {{(EXT_BITS-FIELD_BITS){req_data.coord_z[FIELD_BITS-1]}}, req_data.coord_z};
   assign in_point = {x_ext[CB-1:0], y_ext[CB-1:0], z_ext[CB-1:0]};

   nrps_point_store #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_data.point_index)),
      .wr_data (in_point),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nrps_dist_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .q_load    (start_query),
      .q_point   (in_point),
      .in_valid  (rd_en),
      .pt_data   (rd_data),
      .out_valid (dist_valid),
      .out_dist  (dist_sum)
   );

   nrps_scan_ctrl #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start_query (start_query),
      .point_count (point_count_ff),
      .dist_valid  (dist_valid),
      .dist_sum    (dist_sum),
      .busy        (busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // a response beat only ever appears once the scan has finished
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while scan in progress");

   // a query over a non-empty store must start a scan
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start_query && (point_count_ff != '0)) |=> busy)
      else $error("query did not start a scan");

   // a write completes at once and produces no response
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.req_type == REQ_WRITE)) |=> (!busy && !rsp_valid))
      else $error("write beat raised busy or a response");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for nearest_route_point_search_unit
// Fills the point store, sweeps point_count from empty through small and
// mid sizes, and checks every query response against a nearest-point
// predictor with lowest-index tie breaking.
// ----------------------------------------------------------------------------
module testbench;
   import nrps_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 560;

   localparam logic signed [FIELD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [FIELD_BITS-1:0] COORD_MIN = 24'sh800000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   nrps_req_type          req_data = '0;
   logic                  rsp_valid;
   nrps_rsp_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data = '0;

   // point store and count as the block should hold them
   bit signed [FIELD_BITS-1:0] point_x [DEF_MAX_POINTS];
   bit signed [FIELD_BITS-1:0] point_y [DEF_MAX_POINTS];
   bit signed [FIELD_BITS-1:0] point_z [DEF_MAX_POINTS];
   logic [COUNT_BITS-1:0]      live_count = '0;

   // what the stimulus has sent so far, used to shape later beats
   bit signed [FIELD_BITS-1:0] sent_x [DEF_MAX_POINTS];
   bit signed [FIELD_BITS-1:0] sent_y [DEF_MAX_POINTS];
   bit signed [FIELD_BITS-1:0] sent_z [DEF_MAX_POINTS];
   bit                         sent_written [DEF_MAX_POINTS];
   int                         sent_count = 0;

   nrps_req_type pending_reqs [$];
   nrps_rsp_type expected_nearest [$];
   int           send_idle_pct = 30;
   int           mismatch_count = 0;
   int           quiet_cycles = 0;

   nearest_route_point_search_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned squared_gap(input logic signed [FIELD_BITS-1:0] a,
                                                   input logic signed [FIELD_BITS-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return unsigned'(d * d);
   endfunction

   function automatic nrps_rsp_type nearest_point(input nrps_req_type q);
      nrps_rsp_type    res;
      longint unsigned gap_total;
      longint unsigned best;
      int              n;
      int              best_idx;
      n = (live_count > DEF_MAX_POINTS) ? DEF_MAX_POINTS : int'(live_count);
      best = 0;
      best_idx = 0;
      for (int i = 0; i < n; i++) begin
         gap_total = squared_gap(q.coord_x, point_x[i]) + squared_gap(q.coord_y, point_y[i])
                   + squared_gap(q.coord_z, point_z[i]);
         // strict compare keeps the lowest index on ties
         if (i == 0 || gap_total < best) begin
            best = gap_total;
            best_idx = i;
         end
      end
      res.found = (n != 0);
      res.closest_index = INDEX_BITS'(best_idx);
      return res;
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] rand_coord();
      case ($urandom_range(7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3, 4: return FIELD_BITS'(int'($urandom_range(64)) - 32);
         default: return FIELD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] nudge(input logic signed [FIELD_BITS-1:0] c);
      return c + FIELD_BITS'(int'($urandom_range(16)) - 8);
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] corner();
      return $urandom_range(1) ? COORD_MAX : COORD_MIN;
   endfunction

   task automatic queue_write(input int idx, input logic signed [FIELD_BITS-1:0] x,
                              input logic signed [FIELD_BITS-1:0] y,
                              input logic signed [FIELD_BITS-1:0] z);
      nrps_req_type item;
      item.req_type    = REQ_WRITE;
      item.point_index = INDEX_BITS'(idx);
      item.coord_x     = x;
      item.coord_y     = y;
      item.coord_z     = z;
      pending_reqs.push_back(item);
      sent_x[idx] = x;
      sent_y[idx] = y;
      sent_z[idx] = z;
      sent_written[idx] = 1'b1;
   endtask

   task automatic queue_query(input logic signed [FIELD_BITS-1:0] x,
                              input logic signed [FIELD_BITS-1:0] y,
                              input logic signed [FIELD_BITS-1:0] z);
      nrps_req_type item;
      item.req_type    = REQ_QUERY;
      item.point_index = INDEX_BITS'($urandom_range(DEF_MAX_POINTS - 1));
      item.coord_x     = x;
      item.coord_y     = y;
      item.coord_z     = z;
      pending_reqs.push_back(item);
   endtask

   task automatic queue_random_query();
      int live;
      int j;
      live = (sent_count > DEF_MAX_POINTS) ? DEF_MAX_POINTS : sent_count;
      j = (live > 0) ? $urandom_range(live - 1) : 0;
      case ($urandom_range(3))
         0: queue_query(rand_coord(), rand_coord(), rand_coord());
         1: queue_query(sent_x[j], sent_y[j], sent_z[j]);
         2: queue_query(nudge(sent_x[j]), nudge(sent_y[j]), nudge(sent_z[j]));
         default: queue_query(corner(), corner(), corner());
      endcase
   endtask

   // wait until every beat is sent and answered, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      while (pending_reqs.size() != 0 || start || busy || expected_nearest.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_point_count(input int value);
      settle();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= COUNT_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      live_count = COUNT_BITS'(value);
      sent_count = value;
   endtask

   // request driver: model every accepted beat, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            if (req_data.req_type == REQ_QUERY) begin
               expected_nearest.push_back(nearest_point(req_data));
            end else begin
               point_x[req_data.point_index] = req_data.coord_x;
               point_y[req_data.point_index] = req_data.coord_y;
               point_z[req_data.point_index] = req_data.coord_z;
            end
         end
         if (start && busy) begin
            // hold the beat until the block takes it
         end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      nrps_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_nearest.size() == 0) begin
            $error("unexpected response beat: found %0d, closest_index %0d",
                   rsp_data.found, rsp_data.closest_index);
            mismatch_count++;
         end else begin
            want = expected_nearest.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
               mismatch_count++;
            end
            if (rsp_data.closest_index !== want.closest_index) begin
               $error("closest_index: expected %0d, actual %0d",
                      want.closest_index, rsp_data.closest_index);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("nearest_route_point_search_unit regression: fail");
         $finish;
      end
   end

   initial begin
      int random_items;
      int cnt;
      int live;
      int n_ops;
      int idx;
      int k;
      random_items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, extreme corners, a tie between two entries
      send_idle_pct = 30;
      set_point_count(0);
      queue_query(COORD_MAX, COORD_MAX, COORD_MAX);
      queue_query(COORD_MIN, COORD_MIN, COORD_MIN);
      queue_write(0, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_write(1, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_write(2, 0, 0, 0);
      queue_write(3, 0, 0, 0);
      queue_write(DEF_MAX_POINTS - 1, -1, 1, -1);
      set_point_count(4);
      queue_query(COORD_MAX, COORD_MAX, COORD_MAX);
      queue_query(COORD_MIN, COORD_MIN, COORD_MIN);
      queue_query(0, 0, 0);
      queue_query(1, -1, 0);
      queue_query(COORD_MIN, COORD_MAX, COORD_MIN);
      queue_query(COORD_MAX, COORD_MIN, COORD_MAX);
      set_point_count(1);
      queue_query(COORD_MIN, COORD_MIN, COORD_MIN);
      queue_query(0, 0, 0);

      // random phases with small stores; idling pattern shifts with progress
      while (random_items < RANDOM_ITEMS) begin
         send_idle_pct = (random_items < RANDOM_ITEMS / 3) ? 30 :
                         (random_items < 2 * RANDOM_ITEMS / 3) ? 85 : 0;
         case ($urandom_range(9))
            0: cnt = 0;
            1: cnt = $urandom_range(65, 200);
            default: cnt = $urandom_range(1, 64);
         endcase
         set_point_count(cnt);
         // every entry in use must hold a point before it is scanned
         for (int i = 0; i < cnt; i++) begin
            if (!sent_written[i]) begin
               queue_write(i, rand_coord(), rand_coord(), rand_coord());
               random_items++;
            end
         end
         live = cnt;
         n_ops = $urandom_range(8, 30);
         for (int op = 0; op < n_ops; op++) begin
            if ($urandom_range(99) < 55) begin
               queue_random_query();
            end else begin
               idx = (live > 0 && $urandom_range(9) < 7) ? $urandom_range(live - 1)
                                                         : $urandom_range(DEF_MAX_POINTS - 1);
               k = (live > 0) ? $urandom_range(live - 1) : 0;
               // copy an entry in use now and then to force ties
               if (live > 0 && sent_written[k] && $urandom_range(4) == 0)
                  queue_write(idx, sent_x[k], sent_y[k], sent_z[k]);
               else
                  queue_write(idx, rand_coord(), rand_coord(), rand_coord());
            end
            random_items++;
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("nearest_route_point_search_unit regression: pass");
      else
         $display("nearest_route_point_search_unit regression: fail");
      $finish;
   end

endmodule
